[hw/rtl/co2rd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// co2rd_pkg: shared types and constants of the CO2 report decoder
// Holds the descramble tables, record type codes, queue sizing and the
// record/status structs passed between the front, queue and back.
// ----------------------------------------------------------------------------
package co2rd_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] TypeCo2  = 8'h50;
  localparam logic [7:0] TypeTemp = 8'h42;

  localparam int unsigned SeenCo2Bit  = 0;
  localparam int unsigned SeenTempBit = 1;

  localparam logic signed [19:0] KelvinOffsetCenti = 20'sd27315;
  localparam logic [20:0]        CentiPerRawX4     = 21'd25;

  localparam int unsigned BytePerm [8] = '{2, 4, 0, 7, 1, 6, 5, 3};
  localparam logic [7:0]  ByteKey  [8] = '{8'h84, 8'h47, 8'h56, 8'hD6,
                                           8'h07, 8'h93, 8'h93, 8'h56};

  typedef enum logic {
    KIND_CO2  = 1'b0,
    KIND_TEMP = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] value;
  } item_t;

  typedef struct packed {
    logic             fire;
    logic [1:0]       seen;
  } back_status_t;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic [QCntW-1:0] count;
  } queue_status_t;

  // Byte permutation, byte reversal, rotate right by 3, per-byte key subtract.
  function automatic logic [63:0] descramble(input logic [63:0] w);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] r;
    logic [63:0] c;
    a = '0;
    b = '0;
    c = '0;
    for (int k = 0; k < 8; k++) begin
      a[8*BytePerm[k] +: 8] = w[8*k +: 8];
    end
    for (int k = 0; k < 8; k++) begin
      b[8*(7-k) +: 8] = a[8*k +: 8];
    end
    r = {b[2:0], b[63:3]};
    for (int k = 0; k < 8; k++) begin
      c[8*k +: 8] = r[8*k +: 8] - ByteKey[7-k];
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/co2_sensor_report_decoder_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// co2_sensor_report_decoder_core: CO2 monitor report decoder
// Usage:
//   Input channel (in_valid / in_stall / in_report_word) takes one raw 8-byte
//   report per beat, byte 0 in bits 7:0. A beat is taken at a clock edge with
//   valid high and stall low.
//   Output channel (out_valid / out_stall / out_*) delivers one beat each time
//   both a CO2 and a temperature reading have been seen since the last beat:
//   CO2 in ppm, raw temperature in 1/16 K, and temperature in 0.01 degC.
//   Throughput: one report per cycle while the queue has room (in_stall low);
//   the descramble in the front is combinational.
//   Path: the report that completes the pair is written into the queue;
//   the back then pops it and loads the output register, unless out_stall
//   holds an earlier result.
//   Stall: while out_stall holds a result, the back keeps it and stops
//   popping; the front still takes reports until the 4-entry queue fills,
//   then in_stall rises. Reports of unknown type never enter the queue.
//   Reset (rst_n low, synchronous): readings and seen flags clear to zero,
//   the queue empties and out_valid drops. No clearing pass is needed.
// ----------------------------------------------------------------------------
module co2_sensor_report_decoder_core
  import co2rd_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [63:0]   in_report_word,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [15:0]        out_co2_ppm,
  output logic [15:0]        out_temperature_raw,
  output logic signed [19:0] out_temperature_centi_c
);

  logic          in_accept;
  logic          f_push;
  item_t         f_item;
  logic          q_full;
  logic          q_not_empty;
  item_t         q_head;
  logic          q_pop;
  queue_status_t q_status;
  back_status_t  b_status;

  // Stall the sender only when the queue has no room left.
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  // Front: descramble and drop unknown record types.
  co2rd_front u_front (
    .accept      (in_accept),
    .report_word (in_report_word),
    .push        (f_push),
    .item        (f_item)
  );

  // Queue: decouple the front from output backpressure.
  co2rd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_item (f_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head),
    .status    (q_status)
  );

  // Back: hold latest readings, emit a beat when the pair is complete.
  co2rd_back u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .q_not_empty             (q_not_empty),
    .q_head                  (q_head),
    .q_pop                   (q_pop),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_co2_ppm             (out_co2_ppm),
    .out_temperature_raw     (out_temperature_raw),
    .out_temperature_centi_c (out_temperature_centi_c),
    .status                  (b_status)
  );

  // A completed pair leaves both seen flags clear.
  a_fire_clears_seen : assert property (
    @(posedge clk) disable iff (!rst_n)
    b_status.fire |=> (b_status.seen == 2'b00)
  ) else $error("seen flags not cleared after result");

  // The back never pops an empty queue.
  a_no_pop_empty : assert property (
    @(posedge clk) disable iff (!rst_n)
    q_status.pop |-> (q_status.count != '0)
  ) else $error("pop from empty queue");

  // The queue never pushes past its depth.
  a_no_push_full : assert property (
    @(posedge clk) disable iff (!rst_n)
    (q_status.push && !q_status.pop) |-> (q_status.count != QCntW'(QDepth))
  ) else $error("push into full queue");

  // A result beat is only raised by a completed pair.
  a_valid_source : assert property (
    @(posedge clk) disable iff (!rst_n)
    (!out_valid || !out_stall) && !b_status.fire |=> !out_valid
  ) else $error("output valid without a completed pair");

endmodule
`default_nettype wire

[hw/rtl/co2rd_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// co2rd_front: report descramble and classify
// Descrambles each accepted report and pushes CO2 and temperature records
// into the queue; reports of any other type are dropped here.
// ----------------------------------------------------------------------------
module co2rd_front
  import co2rd_pkg::*;
(
  input  wire logic        accept,
  input  wire logic [63:0] report_word,
  output logic             push,
  output item_t            item
);

  logic [63:0] plain;
  logic [7:0]  rec_type;

  always_comb begin
    plain      = descramble(report_word);
    rec_type   = plain[63:56];
    item.value = plain[55:40];
    item.kind  = KIND_CO2;
    push       = 1'b0;
    case (rec_type)
      TypeCo2: begin
        item.kind = KIND_CO2;
        push      = accept;
      end
      TypeTemp: begin
        item.kind = KIND_TEMP;
        push      = accept;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/co2rd_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// co2rd_queue: short record queue between front and back
// Small circular buffer; simultaneous push and pop are allowed.
// ----------------------------------------------------------------------------
module co2rd_queue
  import co2rd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire item_t  push_item,
  input  wire logic   pop,
  output logic        full,
  output logic        not_empty,
  output item_t       head,
  output queue_status_t status
);

  item_t            slot_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0] count_r, count_nxt;

  assign full      = (count_r == QCntW'(QDepth));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  assign status.push  = push;
  assign status.pop   = pop;
  assign status.count = count_r;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCntW'(push) - QCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/co2rd_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// co2rd_back: reading store and result builder
// Pops records, keeps the latest readings and seen flags, and loads the
// output register once both readings have been seen.
// ----------------------------------------------------------------------------
module co2rd_back
  import co2rd_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_not_empty,
  input  wire item_t         q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [15:0]        out_co2_ppm,
  output logic [15:0]        out_temperature_raw,
  output logic signed [19:0] out_temperature_centi_c,
  output back_status_t       status
);

  logic [15:0]        co2_r, co2_nxt;
  logic [15:0]        temp_r, temp_nxt;
  logic [1:0]         seen_r, seen_nxt, seen_mark;
  logic               out_valid_r, out_valid_nxt;
  logic               fire;
  logic [20:0]        prod;
  logic signed [19:0] centi;

  assign out_valid     = out_valid_r;
  assign status.fire   = fire;
  assign status.seen   = seen_r;

  always_comb begin
    q_pop         = q_not_empty && (!out_valid_r || !out_stall);
    co2_nxt       = co2_r;
    temp_nxt      = temp_r;
    seen_mark     = seen_r;
    seen_nxt      = seen_r;
    fire          = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    if (q_pop) begin
      case (q_head.kind)
        KIND_CO2: begin
          co2_nxt               = q_head.value;
          seen_mark[SeenCo2Bit] = 1'b1;
        end
        KIND_TEMP: begin
          temp_nxt               = q_head.value;
          seen_mark[SeenTempBit] = 1'b1;
        end
        default: begin
          seen_mark = seen_r;
        end
      endcase
      seen_nxt = seen_mark;
      if (&seen_mark) begin
        fire          = 1'b1;
        seen_nxt      = '0;
        out_valid_nxt = 1'b1;
      end
    end
    // raw * 25 / 4, truncated, then shift from kelvin to Celsius
    prod  = {5'b0, temp_nxt} * CentiPerRawX4;
    centi = $signed({1'b0, prod[20:2]}) - KelvinOffsetCenti;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      co2_r       <= '0;
      temp_r      <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      co2_r       <= co2_nxt;
      temp_r      <= temp_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_co2_ppm             <= co2_nxt;
      out_temperature_raw     <= temp_nxt;
      out_temperature_centi_c <= centi;
    end
  end

endmodule
`default_nettype wire

[verif/co2_reading_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// co2_reading_checker: reading predictor and comparator for the report decoder
// Watches both channels of the decoder, descrambles every accepted report
// beat, tracks the stored readings and seen flags, and compares each result
// beat field by field with the oldest predicted reading.
// ----------------------------------------------------------------------------
module co2_reading_checker
  import co2rd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [63:0]        in_report_word,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic [15:0]        out_co2_ppm,
  input  wire logic [15:0]        out_temperature_raw,
  input  wire logic signed [19:0] out_temperature_centi_c,
  output int                      mismatches,
  output int                      readings_due
);

  typedef struct packed {
    logic [15:0]        co2;
    logic [15:0]        temp_raw;
    logic signed [19:0] centi;
  } reading_t;

  localparam int unsigned ShuffleTab [8] = '{2, 4, 0, 7, 1, 6, 5, 3};
  localparam logic [7:0]  KeyTab     [8] = '{8'h84, 8'h47, 8'h56, 8'hD6,
                                             8'h07, 8'h93, 8'h93, 8'h56};
  localparam int          KelvinCenti    = 27315;

  logic [15:0] co2_now;
  logic [15:0] temp_now;
  logic [1:0]  seen_now;
  reading_t    predicted_readings [$];

  initial begin
    mismatches   = 0;
    readings_due = 0;
  end

  function automatic logic [63:0] unscramble(input logic [63:0] w);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] r;
    logic [63:0] c;
    a = '0;
    b = '0;
    c = '0;
    for (int k = 0; k < 8; k++) a[8*ShuffleTab[k] +: 8] = w[8*k +: 8];
    for (int k = 0; k < 8; k++) b[8*(7-k) +: 8] = a[8*k +: 8];
    r = {b[2:0], b[63:3]};
    for (int k = 0; k < 8; k++) c[8*k +: 8] = r[8*k +: 8] - KeyTab[7-k];
    return c;
  endfunction

  // Update the stored readings from one report; queue a reading once both
  // kinds have been seen.
  task automatic absorb_report(input logic [63:0] w);
    logic [63:0] plain;
    logic [7:0]  rec;
    logic [15:0] val;
    int unsigned raw;
    int          centi;
    reading_t    rd;
    plain = unscramble(w);
    rec   = plain[63:56];
    val   = plain[55:40];
    if (rec == TypeCo2) begin
      co2_now     = val;
      seen_now[0] = 1'b1;
    end else if (rec == TypeTemp) begin
      temp_now    = val;
      seen_now[1] = 1'b1;
    end
    if (seen_now == 2'b11) begin
      seen_now    = 2'b00;
      raw         = temp_now;
      centi       = int'((raw * 25) >> 2) - KelvinCenti;
      rd.co2      = co2_now;
      rd.temp_raw = temp_now;
      rd.centi    = centi[19:0];
      predicted_readings.push_back(rd);
    end
  endtask

  task automatic compare_reading();
    reading_t rd;
    if (predicted_readings.size() == 0) begin
      $error("result beat with no reading pending: co2 %0d raw %0d centi %0d",
             out_co2_ppm, out_temperature_raw, out_temperature_centi_c);
      mismatches++;
    end else begin
      rd = predicted_readings.pop_front();
      if (out_co2_ppm !== rd.co2) begin
        $error("out_co2_ppm: expected %0d, actual %0d", rd.co2, out_co2_ppm);
        mismatches++;
      end
      if (out_temperature_raw !== rd.temp_raw) begin
        $error("out_temperature_raw: expected %0d, actual %0d",
               rd.temp_raw, out_temperature_raw);
        mismatches++;
      end
      if (out_temperature_centi_c !== rd.centi) begin
        $error("out_temperature_centi_c: expected %0d, actual %0d",
               rd.centi, out_temperature_centi_c);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      co2_now  = '0;
      temp_now = '0;
      seen_now = '0;
      predicted_readings.delete();
    end else begin
      if (out_valid && !out_stall) compare_reading();
      if (in_valid && !in_stall) absorb_report(in_report_word);
    end
    readings_due = predicted_readings.size();
  end

endmodule

[verif/co2_sensor_report_decoder_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// co2_sensor_report_decoder_core_test: top of the report decoder testbench
// Builds scrambled sensor reports from chosen record types and readings,
// drives them with random idle gaps and random result back pressure, and
// leaves prediction and comparison to the reading checker beside the block.
// ----------------------------------------------------------------------------
module co2_sensor_report_decoder_core_test;
  import co2rd_pkg::*;

  // Own copies of the scramble tables, used to build reports from plain
  // record contents.
  localparam int unsigned ShuffleTab [8] = '{2, 4, 0, 7, 1, 6, 5, 3};
  localparam logic [7:0]  KeyTab     [8] = '{8'h84, 8'h47, 8'h56, 8'hD6,
                                             8'h07, 8'h93, 8'h93, 8'h56};
  localparam int          RandomReadings = 300;
  localparam int          CycleLimit     = 400000;
  localparam int          DrainCycles    = 16;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [63:0]        in_report_word;
  logic               out_valid;
  logic               out_stall;
  logic [15:0]        out_co2_ppm;
  logic [15:0]        out_temperature_raw;
  logic signed [19:0] out_temperature_centi_c;

  int   mismatches;
  int   readings_due;
  int   cycle_count;
  int   stall_left;
  logic calm;
  logic draining;

  co2_sensor_report_decoder_core dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_report_word          (in_report_word),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_co2_ppm             (out_co2_ppm),
    .out_temperature_raw     (out_temperature_raw),
    .out_temperature_centi_c (out_temperature_centi_c)
  );

  co2_reading_checker reading_check (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_report_word          (in_report_word),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_co2_ppm             (out_co2_ppm),
    .out_temperature_raw     (out_temperature_raw),
    .out_temperature_centi_c (out_temperature_centi_c),
    .mismatches              (mismatches),
    .readings_due            (readings_due)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Bound the run: a hang anywhere ends in a failure.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Idle length for either side: mostly none or short, now and then long.
  // Calm stretches run with no idling at all.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Invert the descramble: add the key per byte, rotate left by 3,
  // reverse the bytes, then undo the byte shuffle.
  function automatic logic [63:0] build_report(input logic [7:0]  rec,
                                               input logic [15:0] val,
                                               input logic [39:0] fill);
    logic [63:0] plain;
    logic [63:0] keyed;
    logic [63:0] rolled;
    logic [63:0] shuffled;
    logic [63:0] raw;
    plain = {rec, val, fill};
    for (int k = 0; k < 8; k++) keyed[8*k +: 8] = plain[8*k +: 8] + KeyTab[7-k];
    rolled = {keyed[60:0], keyed[63:61]};
    for (int k = 0; k < 8; k++) shuffled[8*k +: 8] = rolled[8*(7-k) +: 8];
    for (int k = 0; k < 8; k++) raw[8*k +: 8] = shuffled[8*ShuffleTab[k] +: 8];
    return raw;
  endfunction

  function automatic logic [39:0] random_fill();
    return {8'($urandom_range(0, 255)), 32'($urandom())};
  endfunction

  // Bias readings toward the ends of the range.
  function automatic logic [15:0] random_reading();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  // Any record type except the two that the block stores.
  function automatic logic [7:0] stray_type();
    logic [7:0] t;
    t = 8'($urandom_range(0, 255));
    if (t == TypeCo2 || t == TypeTemp) t = t ^ 8'h01;
    return t;
  endfunction

  // Present one report beat, after an optional idle gap, and hold it until
  // the block takes it. Entered and left at a falling edge.
  task automatic send_report(input logic [63:0] w);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_report_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_reading(input logic [7:0] rec, input logic [15:0] val);
    send_report(build_report(rec, val, random_fill()));
  endtask

  // Result side back pressure: drop it entirely during reset and drain.
  always @(negedge clk) begin
    if (!rst_n || draining) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall  <= 1'b0;
      stall_left = idle_len();
    end
  end

  initial begin
    int r;
    int good_items;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_report_word = '0;
    out_stall      = 1'b0;
    stall_left     = 0;
    calm           = 1'b0;
    draining       = 1'b0;
    good_items     = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extreme readings with all-zero and all-one filler.
    send_report(build_report(TypeCo2, 16'h0000, 40'h00_0000_0000));
    send_report(build_report(TypeTemp, 16'h0000, 40'h00_0000_0000));
    send_report(build_report(TypeCo2, 16'hFFFF, 40'hFF_FFFF_FFFF));
    send_report(build_report(TypeTemp, 16'hFFFF, 40'hFF_FFFF_FFFF));
    // Temperature ahead of CO2.
    send_reading(TypeTemp, 16'd4660);
    send_reading(TypeCo2, 16'd415);
    // Overwrite a held CO2 reading, with stray types in between.
    send_reading(TypeCo2, 16'd100);
    send_reading(8'h00, 16'd1);
    send_reading(TypeCo2, 16'd800);
    send_reading(8'hFF, 16'd2);
    send_reading(8'h51, 16'd3);
    send_reading(8'h43, 16'd4);
    send_reading(TypeTemp, 16'h1280);
    // Overwrite a held temperature reading.
    send_reading(TypeTemp, 16'd5);
    send_reading(TypeTemp, 16'd6);
    send_reading(TypeCo2, 16'd400);
    // Raw words: blank, all ones and noise.
    send_report(64'h0000_0000_0000_0000);
    send_report(64'hFFFF_FFFF_FFFF_FFFF);
    send_report({$urandom(), $urandom()});
    // Truncation of the quarter step.
    send_reading(TypeTemp, 16'd1);
    send_reading(TypeCo2, 16'd1);
    send_reading(TypeTemp, 16'd3);
    send_reading(TypeCo2, 16'd2);

    // Random: mostly well-formed readings, some stray types and noise.
    while (good_items < RandomReadings) begin
      if ($urandom_range(0, 63) == 0) calm = ~calm;
      r = $urandom_range(0, 99);
      if (r < 40) begin
        send_reading(TypeCo2, random_reading());
        good_items++;
      end else if (r < 80) begin
        send_reading(TypeTemp, random_reading());
        good_items++;
      end else if (r < 90) begin
        send_reading(stray_type(), random_reading());
      end else begin
        send_report({$urandom(), $urandom()});
      end
    end

    // Drain: release back pressure, wait for every reading, then wait out the
    // drain period to catch any stray result beat.
    in_valid <= 1'b0;
    draining = 1'b1;
    while (readings_due != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/co2rd_pkg.sv
hw/rtl/co2rd_front.sv
hw/rtl/co2rd_queue.sv
hw/rtl/co2rd_back.sv
hw/rtl/co2_sensor_report_decoder_core.sv
verif/co2_reading_checker.sv
verif/co2_sensor_report_decoder_core_test.sv
